// File: src/cau_pkg.sv
`timescale 1ns / 1ps
package cau_pkg;

  localparam int FIELD_BITS = 32;
  localparam int PROD_BITS  = 64;
  localparam int SUM_BITS   = 66;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_GT   = 3'd4,
    OP_LT   = 3'd5,
    OP_EQ   = 3'd6,
    OP_CONJ = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  // Sideband carried alongside the divider lanes
  typedef struct packed {
    logic [PROD_BITS-1:0] den;
    logic                 neg_re;
    logic                 neg_im;
    logic                 cmp;
    logic                 div0;
  } side_t;

endpackage

// File: src/cau_in_if.sv
`timescale 1ns / 1ps
interface cau_in_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          operation;
  logic signed [cau_pkg::FIELD_BITS-1:0] a_real;
  logic signed [cau_pkg::FIELD_BITS-1:0] a_imag;
  logic signed [cau_pkg::FIELD_BITS-1:0] b_real;
  logic signed [cau_pkg::FIELD_BITS-1:0] b_imag;

  modport source (output valid, operation, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, operation, a_real, a_imag, b_real, b_imag, output ready);
endinterface

// File: src/cau_out_if.sv
`timescale 1ns / 1ps
interface cau_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cau_pkg::FIELD_BITS-1:0] res_real;
  logic signed [cau_pkg::FIELD_BITS-1:0] res_imag;
  logic                                  compare_true;
  logic [1:0]                            status;

  modport source (output valid, res_real, res_imag, compare_true, status, input ready);
  modport sink   (input valid, res_real, res_imag, compare_true, status, output ready);
endinterface

// File: src/cau_front.sv
`timescale 1ns / 1ps
module cau_front #(
  parameter int FRAC_BITS = 16,
  parameter int QW        = 80
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  cau_in_if.sink             in_ch,
  output logic               out_valid,
  output cau_pkg::side_t     out_side,
  output logic [QW-1:0]      out_dq_re,
  output logic [QW-1:0]      out_dq_im
);

  localparam int FB = cau_pkg::FIELD_BITS;
  localparam int PB = cau_pkg::PROD_BITS;
  localparam int SB = cau_pkg::SUM_BITS;

  // stage 0: registered operands
  logic                 v0_r;
  cau_pkg::op_t         op0_r;
  logic signed [FB-1:0] ar0_r, ai0_r, br0_r, bi0_r;

  // stage 1: products
  logic                 v1_r;
  cau_pkg::op_t         op1_r;
  logic signed [FB-1:0] ar1_r, ai1_r, br1_r, bi1_r;
  logic signed [PB-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [PB-1:0] s_aa_r, s_ai_r, s_br_r, s_bi_r;

  // stage 2: signed parts to dividend form
  logic signed [SB-1:0] v_re, v_im, n_re, n_im;
  logic [PB-1:0]        mag_re, mag_im, ma, mb;
  logic [QW-1:0]        dq_re_nxt, dq_im_nxt;
  cau_pkg::side_t       side_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r      <= 1'b0;
      v1_r      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0_r      <= in_ch.valid;
      v1_r      <= v0_r;
      out_valid <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op0_r  <= cau_pkg::op_t'(in_ch.operation);
      ar0_r  <= in_ch.a_real;
      ai0_r  <= in_ch.a_imag;
      br0_r  <= in_ch.b_real;
      bi0_r  <= in_ch.b_imag;
      op1_r  <= op0_r;
      ar1_r  <= ar0_r;
      ai1_r  <= ai0_r;
      br1_r  <= br0_r;
      bi1_r  <= bi0_r;
      p_rr_r <= ar0_r * br0_r;
      p_ii_r <= ai0_r * bi0_r;
      p_ri_r <= ar0_r * bi0_r;
      p_ir_r <= ai0_r * br0_r;
      s_aa_r <= ar0_r * ar0_r;
      s_ai_r <= ai0_r * ai0_r;
      s_br_r <= br0_r * br0_r;
      s_bi_r <= bi0_r * bi0_r;
      out_side  <= side_nxt;
      out_dq_re <= dq_re_nxt;
      out_dq_im <= dq_im_nxt;
    end
  end

  always_comb begin
    ma = PB'(s_aa_r) + PB'(s_ai_r);
    mb = PB'(s_br_r) + PB'(s_bi_r);
    v_re = '0;
    v_im = '0;
    side_nxt.den    = PB'(1);
    side_nxt.cmp    = 1'b0;
    side_nxt.div0   = 1'b0;
    unique case (op1_r)
      cau_pkg::OP_ADD: begin
        v_re = SB'(ar1_r) + SB'(br1_r);
        v_im = SB'(ai1_r) + SB'(bi1_r);
      end
      cau_pkg::OP_SUB: begin
        v_re = SB'(ar1_r) - SB'(br1_r);
        v_im = SB'(ai1_r) - SB'(bi1_r);
      end
      cau_pkg::OP_MUL: begin
        v_re = SB'(p_rr_r) - SB'(p_ii_r);
        v_im = SB'(p_ri_r) + SB'(p_ir_r);
      end
      cau_pkg::OP_DIV: begin
        if (mb == '0) begin
          side_nxt.div0 = 1'b1;
        end else begin
          v_re         = SB'(p_rr_r) + SB'(p_ii_r);
          v_im         = SB'(p_ir_r) - SB'(p_ri_r);
          side_nxt.den = mb;
        end
      end
      cau_pkg::OP_GT:   side_nxt.cmp = (ma > mb);
      cau_pkg::OP_LT:   side_nxt.cmp = (ma < mb);
      cau_pkg::OP_EQ:   side_nxt.cmp = (ar1_r == br1_r) && (ai1_r == bi1_r);
      cau_pkg::OP_CONJ: begin
        v_re = SB'(ar1_r);
        v_im = -SB'(ai1_r);
      end
      default: ;
    endcase
    side_nxt.neg_re = v_re[SB-1];
    side_nxt.neg_im = v_im[SB-1];
    n_re   = v_re[SB-1] ? -v_re : v_re;
    n_im   = v_im[SB-1] ? -v_im : v_im;
    mag_re = n_re[PB-1:0];
    mag_im = n_im[PB-1:0];
    // divider lanes pass a dividend over den=1 untouched
    unique case (op1_r)
      cau_pkg::OP_MUL: begin
        dq_re_nxt = QW'(mag_re >> FRAC_BITS);
        dq_im_nxt = QW'(mag_im >> FRAC_BITS);
      end
      cau_pkg::OP_DIV: begin
        dq_re_nxt = QW'(mag_re) << FRAC_BITS;
        dq_im_nxt = QW'(mag_im) << FRAC_BITS;
      end
      default: begin
        dq_re_nxt = QW'(mag_re);
        dq_im_nxt = QW'(mag_im);
      end
    endcase
  end

endmodule

// File: src/cau_div_cell.sv
`timescale 1ns / 1ps
module cau_div_cell #(
  parameter int QW = 80
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  cau_pkg::side_t                    in_side,
  input  logic [cau_pkg::PROD_BITS-1:0]     in_rem_re,
  input  logic [QW-1:0]                     in_dq_re,
  input  logic [cau_pkg::PROD_BITS-1:0]     in_rem_im,
  input  logic [QW-1:0]                     in_dq_im,
  output logic                              out_valid,
  output cau_pkg::side_t                    out_side,
  output logic [cau_pkg::PROD_BITS-1:0]     out_rem_re,
  output logic [QW-1:0]                     out_dq_re,
  output logic [cau_pkg::PROD_BITS-1:0]     out_rem_im,
  output logic [QW-1:0]                     out_dq_im
);

  localparam int PB = cau_pkg::PROD_BITS;

  logic [PB:0]   t_re, t_im, d_ext;
  logic          ge_re, ge_im;
  logic [PB-1:0] rem_re_nxt, rem_im_nxt;

  // one restoring step per lane: shift in the next dividend bit, retire one quotient bit
  always_comb begin
    d_ext      = {1'b0, in_side.den};
    t_re       = {in_rem_re, in_dq_re[QW-1]};
    t_im       = {in_rem_im, in_dq_im[QW-1]};
    ge_re      = (t_re >= d_ext);
    ge_im      = (t_im >= d_ext);
    rem_re_nxt = ge_re ? PB'(t_re - d_ext) : t_re[PB-1:0];
    rem_im_nxt = ge_im ? PB'(t_im - d_ext) : t_im[PB-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side   <= in_side;
      out_rem_re <= rem_re_nxt;
      out_rem_im <= rem_im_nxt;
      out_dq_re  <= {in_dq_re[QW-2:0], ge_re};
      out_dq_im  <= {in_dq_im[QW-2:0], ge_im};
    end
  end

endmodule

// File: src/complex_arithmetic_unit_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Content
// in_ch     in   operation, a_real, a_imag, b_real, b_imag
// out_ch    out  res_real, res_imag, compare_true, status
//
// One transaction enters per cycle unless the pipeline is stalled; a transaction passes through
// three front stages (operands, products, sums), one divider cell per quotient bit
// (64 + FRAC_BITS of them), and the saturating output register.
// Synchronous active-low reset clears every stage valid; no clearing pass.
// A stalled result holds the whole pipeline, and in_ch.ready drops with it.
module complex_arithmetic_unit_top #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  cau_in_if.sink    in_ch,
  cau_out_if.source out_ch
);

  localparam int PB = cau_pkg::PROD_BITS;
  localparam int FB = cau_pkg::FIELD_BITS;
  localparam int QW = PB + FRAC_BITS;

  logic                en;
  logic                valid_c [QW+1];
  cau_pkg::side_t      side_c  [QW+1];
  logic [PB-1:0]       rem_re_c[QW+1];
  logic [PB-1:0]       rem_im_c[QW+1];
  logic [QW-1:0]       dq_re_c [QW+1];
  logic [QW-1:0]       dq_im_c [QW+1];

  logic                out_valid_r;
  logic [QW-1:0]       lim_re, lim_im;
  logic                ovf_re, ovf_im;
  logic [PB-1:0]       m_re, m_im, s_re, s_im;
  logic [FB-1:0]       res_re_nxt, res_im_nxt;
  cau_pkg::status_t    status_nxt;

  // advance unless a result is waiting and not taken
  assign en          = out_ch.ready || !out_valid_r;
  assign in_ch.ready = en;

  cau_front #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_ch     (in_ch),
    .out_valid (valid_c[0]),
    .out_side  (side_c[0]),
    .out_dq_re (dq_re_c[0]),
    .out_dq_im (dq_im_c[0])
  );

  assign rem_re_c[0] = '0;
  assign rem_im_c[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    cau_div_cell #(.QW(QW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .in_valid   (valid_c[i]),
      .in_side    (side_c[i]),
      .in_rem_re  (rem_re_c[i]),
      .in_dq_re   (dq_re_c[i]),
      .in_rem_im  (rem_im_c[i]),
      .in_dq_im   (dq_im_c[i]),
      .out_valid  (valid_c[i+1]),
      .out_side   (side_c[i+1]),
      .out_rem_re (rem_re_c[i+1]),
      .out_dq_re  (dq_re_c[i+1]),
      .out_rem_im (rem_im_c[i+1]),
      .out_dq_im  (dq_im_c[i+1])
    );
  end

  always_comb begin
    lim_re = side_c[QW].neg_re ? (QW'(1) << (WORD_BITS - 1)) : ((QW'(1) << (WORD_BITS - 1)) - 1'b1);
    lim_im = side_c[QW].neg_im ? (QW'(1) << (WORD_BITS - 1)) : ((QW'(1) << (WORD_BITS - 1)) - 1'b1);
    ovf_re = dq_re_c[QW] > lim_re;
    ovf_im = dq_im_c[QW] > lim_im;
    m_re   = ovf_re ? lim_re[PB-1:0] : dq_re_c[QW][PB-1:0];
    m_im   = ovf_im ? lim_im[PB-1:0] : dq_im_c[QW][PB-1:0];
    s_re   = side_c[QW].neg_re ? (PB'(0) - m_re) : m_re;
    s_im   = side_c[QW].neg_im ? (PB'(0) - m_im) : m_im;
    res_re_nxt = s_re[FB-1:0];
    res_im_nxt = s_im[FB-1:0];
    priority if (side_c[QW].div0) begin
      status_nxt = cau_pkg::ST_DIV0;
    end else if (ovf_re || ovf_im) begin
      status_nxt = cau_pkg::ST_OVF;
    end else begin
      status_nxt = cau_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= valid_c[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.res_real     <= res_re_nxt;
      out_ch.res_imag     <= res_im_nxt;
      out_ch.compare_true <= side_c[QW].cmp;
      out_ch.status       <= status_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

// File: bench/complex_arithmetic_unit_top_tb.sv
`timescale 1ns / 1ps
module complex_arithmetic_unit_top_tb;

  localparam int FRAC       = 16;
  localparam int WORD       = 32;
  localparam int LATENCY    = FRAC + 68;
  localparam int HOLD_START = 1000;
  localparam int HOLD_LEN   = 300;
  localparam int IDLE_LIMIT = 4 * (HOLD_LEN + LATENCY) + 200;
  localparam int N_RANDOM   = 1750;

  typedef logic signed [129:0] wide_t;

  typedef struct {
    cau_pkg::op_t           op;
    logic signed [WORD-1:0] ar;
    logic signed [WORD-1:0] ai;
    logic signed [WORD-1:0] br;
    logic signed [WORD-1:0] bi;
  } operands_t;

  typedef struct {
    logic signed [WORD-1:0] re;
    logic signed [WORD-1:0] im;
    logic                   cmp;
    cau_pkg::status_t       st;
  } cplx_result_t;

  logic clk;
  logic rst_n;

  cau_in_if  in_ch ();
  cau_out_if out_ch ();

  complex_arithmetic_unit_top #(
    .FRAC_BITS(FRAC),
    .WORD_BITS(WORD)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  operands_t    pending_ops[$];
  cplx_result_t expected_results[$];
  int           errors;
  int           rx_cycle;
  int           idle_cycles;
  int           sent;
  bit           in_taken;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Clamp to the signed word range; flag any clamping
  function automatic logic signed [WORD-1:0] clamp_word(input wide_t v, inout logic ovf);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (WORD - 1)) - 1;
    lo = -(wide_t'(1) <<< (WORD - 1));
    if (v > hi) begin
      ovf = 1'b1;
      return hi[WORD-1:0];
    end
    if (v < lo) begin
      ovf = 1'b1;
      return lo[WORD-1:0];
    end
    return v[WORD-1:0];
  endfunction

  function automatic cplx_result_t complex_alu(input operands_t t);
    cplx_result_t r;
    wide_t ar, ai, br, bi, ma, mb, scale, nre, nim;
    logic  ovf;
    ar    = t.ar;
    ai    = t.ai;
    br    = t.br;
    bi    = t.bi;
    ma    = ar * ar + ai * ai;
    mb    = br * br + bi * bi;
    scale = wide_t'(1) <<< FRAC;
    ovf   = 1'b0;
    r.re  = '0;
    r.im  = '0;
    r.cmp = 1'b0;
    r.st  = cau_pkg::ST_OK;
    case (t.op)
      cau_pkg::OP_ADD: begin
        r.re = clamp_word(ar + br, ovf);
        r.im = clamp_word(ai + bi, ovf);
      end
      cau_pkg::OP_SUB: begin
        r.re = clamp_word(ar - br, ovf);
        r.im = clamp_word(ai - bi, ovf);
      end
      cau_pkg::OP_MUL: begin
        // signed division truncates toward zero
        r.re = clamp_word((ar * br - ai * bi) / scale, ovf);
        r.im = clamp_word((ar * bi + ai * br) / scale, ovf);
      end
      cau_pkg::OP_DIV: begin
        if (mb == 0) begin
          r.st = cau_pkg::ST_DIV0;
        end else begin
          nre  = (ar * br + ai * bi) * scale;
          nim  = (ai * br - ar * bi) * scale;
          r.re = clamp_word(nre / mb, ovf);
          r.im = clamp_word(nim / mb, ovf);
        end
      end
      cau_pkg::OP_GT:   r.cmp = ma > mb;
      cau_pkg::OP_LT:   r.cmp = ma < mb;
      cau_pkg::OP_EQ:   r.cmp = (ar == br) && (ai == bi);
      default: begin
        r.re = clamp_word(ar, ovf);
        r.im = clamp_word(-ai, ovf);
      end
    endcase
    if (ovf && r.st == cau_pkg::ST_OK) r.st = cau_pkg::ST_OVF;
    return r;
  endfunction

  function automatic logic signed [WORD-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFFFFFF - $urandom_range(0, 3);
      1:       return 32'sh80000000 + $urandom_range(0, 3);
      2, 3:    return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      4:       return $signed($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(input cau_pkg::op_t op, input logic signed [WORD-1:0] ar,
                          input logic signed [WORD-1:0] ai, input logic signed [WORD-1:0] br,
                          input logic signed [WORD-1:0] bi);
    operands_t t;
    t.op = op;
    t.ar = ar;
    t.ai = ai;
    t.br = br;
    t.bi = bi;
    pending_ops.push_back(t);
  endtask

  // Driver: advance on the falling edge after a transaction
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_ops.size() > 0 &&
          ((sent >= 100 && sent < 400) || $urandom_range(0, 99) >= 20)) begin
        operands_t t;
        t = pending_ops.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.operation <= t.op;
        in_ch.a_real    <= t.ar;
        in_ch.a_imag    <= t.ai;
        in_ch.b_real    <= t.br;
        in_ch.b_imag    <= t.bi;
        sent++;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: long hold-off once, no stalls for a while, otherwise random
  always @(negedge clk) begin
    if (!rst_n) begin
      rx_cycle     <= 0;
      out_ch.ready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
        out_ch.ready <= 1'b0;
      else if (rx_cycle >= 400 && rx_cycle < 800)
        out_ch.ready <= 1'b1;
      else
        out_ch.ready <= ($urandom_range(0, 99) >= 20);
    end
  end

  always @(posedge clk) begin
    cplx_result_t exp_r;
    operands_t    t;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        t.op = cau_pkg::op_t'(in_ch.operation);
        t.ar = in_ch.a_real;
        t.ai = in_ch.a_imag;
        t.br = in_ch.b_real;
        t.bi = in_ch.b_imag;
        expected_results.push_back(complex_alu(t));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result re %h im %h", $time, out_ch.res_real,
                   out_ch.res_imag);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.res_real !== exp_r.re) begin
            $display("%0t: res_real expected %h actual %h", $time, exp_r.re, out_ch.res_real);
            errors++;
          end
          if (out_ch.res_imag !== exp_r.im) begin
            $display("%0t: res_imag expected %h actual %h", $time, exp_r.im, out_ch.res_imag);
            errors++;
          end
          if (out_ch.compare_true !== exp_r.cmp) begin
            $display("%0t: compare_true expected %b actual %b", $time, exp_r.cmp,
                     out_ch.compare_true);
            errors++;
          end
          if (out_ch.status !== exp_r.st) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.st, out_ch.status);
            errors++;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic signed [WORD-1:0] v;
    cau_pkg::op_t op;
    errors          = 0;
    rx_cycle        = 0;
    idle_cycles     = 0;
    sent            = 0;
    in_taken        = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = '0;
    in_ch.a_real    = '0;
    in_ch.a_imag    = '0;
    in_ch.b_real    = '0;
    in_ch.b_imag    = '0;
    out_ch.ready    = 1'b0;

    // Directed: every operation, extremes, saturation, divide by zero
    add_item(cau_pkg::OP_ADD, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, -32'sh0001_0000);
    add_item(cau_pkg::OP_ADD, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
    add_item(cau_pkg::OP_SUB, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
    add_item(cau_pkg::OP_SUB, 32'sh0005_8000, 32'sh0, 32'sh0001_4000, 32'sh0);
    add_item(cau_pkg::OP_MUL, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000, -32'sh0001_0000);
    add_item(cau_pkg::OP_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    add_item(cau_pkg::OP_MUL, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    add_item(cau_pkg::OP_MUL, -32'sd3, 32'sd1, 32'sd1, 32'sd0);
    add_item(cau_pkg::OP_DIV, 32'sh0006_0000, 32'sh0002_0000, 32'sh0002_0000, 32'sh0);
    add_item(cau_pkg::OP_DIV, 32'sh0001_0000, 32'sh0001_0000, 32'sh0, 32'sh0);
    add_item(cau_pkg::OP_DIV, 32'sh7FFFFFFF, 32'sh80000000, 32'sd1, 32'sd0);
    add_item(cau_pkg::OP_DIV, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    add_item(cau_pkg::OP_DIV, -32'sd7, 32'sd5, 32'sh0003_0000, 32'sh0001_0000);
    add_item(cau_pkg::OP_GT, 32'sh0003_0000, 32'sh0004_0000, 32'sh0005_0000, 32'sh0);
    add_item(cau_pkg::OP_GT, 32'sh80000000, 32'sh0, 32'sh7FFFFFFF, 32'sh0);
    add_item(cau_pkg::OP_LT, 32'sh0003_0000, 32'sh0004_0000, 32'sh0, 32'sh0005_0000);
    add_item(cau_pkg::OP_LT, 32'sh0, 32'sh0, 32'sh0, 32'sd1);
    add_item(cau_pkg::OP_EQ, 32'sh1234_5678, -32'sd9, 32'sh1234_5678, -32'sd9);
    add_item(cau_pkg::OP_EQ, 32'sh1234_5678, -32'sd9, 32'sh1234_5678, -32'sd8);
    add_item(cau_pkg::OP_CONJ, 32'sh0001_0000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    add_item(cau_pkg::OP_CONJ, 32'sh80000000, 32'sh7FFFFFFF, 32'sh0, 32'sh0);

    for (int i = 0; i < N_RANDOM; i++) begin
      op = cau_pkg::op_t'($urandom_range(0, 7));
      v  = pick_value();
      case ($urandom_range(0, 9))
        // equal operands exercise equality and tied magnitudes
        0:       add_item(op, v, -v, v, -v);
        1:       add_item(op, pick_value(), pick_value(), 32'sh0, 32'sh0);
        2:       add_item(op, pick_value(), pick_value(), pick_value(), 32'sh0);
        default: add_item(op, pick_value(), pick_value(), pick_value(), pick_value());
      endcase
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pending_ops.size() == 0 && !in_ch.valid);
    wait (expected_results.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (expected_results.size() != 0)
        $display("%0t: %0d results never arrived", $time, expected_results.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
